[src/crc8fr_pkg.sv]
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Types, codes and the CRC-8 byte update shared by the framed receiver.
// ----------------------------------------------------------------------------
package crc8fr_pkg;

  // Receive phase
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_TYPE = 3'd1,
    PH_LEN  = 3'd2,
    PH_PAY  = 3'd3,
    PH_CRC  = 3'd4
  } phase_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PREAMBLE    = 3'd0,
    CFG_TYPE_SENSOR = 3'd1,
    CFG_TYPE_ACK    = 3'd2,
    CFG_TYPE_CMD    = 3'd3,
    CFG_CODE_INIT   = 3'd4,
    CFG_CODE_DATA   = 3'd5,
    CFG_CODE_END    = 3'd6,
    CFG_CODE_REBOOT = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 3;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;

  // Frame classes
  localparam logic [1:0] CLS_SENSOR  = 2'd0;
  localparam logic [1:0] CLS_ACK     = 2'd1;
  localparam logic [1:0] CLS_COMMAND = 2'd2;
  localparam logic [1:0] CLS_UNKNOWN = 2'd3;

  // Frame status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CRC_ERR   = 2'd1;
  localparam logic [1:0] ST_BAD_LEN   = 2'd2;
  localparam logic [1:0] ST_TOO_SHORT = 2'd3;

  // Command classes
  localparam logic [2:0] CMD_INIT    = 3'd0;
  localparam logic [2:0] CMD_DATA    = 3'd1;
  localparam logic [2:0] CMD_END     = 3'd2;
  localparam logic [2:0] CMD_REBOOT  = 3'd3;
  localparam logic [2:0] CMD_UNKNOWN = 3'd4;
  localparam logic [2:0] CMD_NONE    = 3'd5;

  localparam logic [7:0] CRC_INIT       = 8'hFF;
  localparam logic [7:0] CRC_POLY       = 8'h07;
  localparam logic [7:0] SENSOR_PAY_LEN = 8'd4;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[src/crc8_framed_packet_receiver_core.sv]
// ----------------------------------------------------------------------------
// crc8_framed_packet_receiver_core
// Preamble / type / length / payload / CRC-8 deframer with sensor latching.
// ----------------------------------------------------------------------------
// Output: a byte's result is registered and shows in the cycle after its transfer.
// Throughput: one byte per cycle; the byte is decoded and the frame state
//   stepped in the cycle of its transfer, the result lands in the output
//   register, and a new byte is taken whenever that register is free or is
//   being emptied in the same cycle.
// Reset: asynchronous, active low; hunting for preamble, CRC seed 0xFF,
//   readings cleared, configuration back to its default codes.
module crc8_framed_packet_receiver_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // byte input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        rx_byte_i,
  input  logic                              sensor_hold_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              result_kind_o,
  output logic [7:0]                        data_byte_o,
  output logic [7:0]                        byte_offset_o,
  output logic [1:0]                        frame_class_o,
  output logic [1:0]                        frame_status_o,
  output logic [2:0]                        command_class_o,
  output logic signed [15:0]                temperature_o,
  output logic signed [15:0]                humidity_o,
  output logic                              reading_valid_o,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [crc8fr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [7:0]                        cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] preamble_q, type_sensor_q, type_ack_q, type_cmd_q;
  logic [7:0] code_init_q, code_data_q, code_end_q, code_reboot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q    <= 8'hAA;
      type_sensor_q <= 8'd1;
      type_ack_q    <= 8'd2;
      type_cmd_q    <= 8'd3;
      code_init_q   <= 8'd1;
      code_data_q   <= 8'd2;
      code_end_q    <= 8'd3;
      code_reboot_q <= 8'd4;
    end else if (cfg_we_i) begin
      unique case (crc8fr_pkg::cfg_idx_e'(cfg_idx_i))
        crc8fr_pkg::CFG_PREAMBLE:    preamble_q    <= cfg_data_i;
        crc8fr_pkg::CFG_TYPE_SENSOR: type_sensor_q <= cfg_data_i;
        crc8fr_pkg::CFG_TYPE_ACK:    type_ack_q    <= cfg_data_i;
        crc8fr_pkg::CFG_TYPE_CMD:    type_cmd_q    <= cfg_data_i;
        crc8fr_pkg::CFG_CODE_INIT:   code_init_q   <= cfg_data_i;
        crc8fr_pkg::CFG_CODE_DATA:   code_data_q   <= cfg_data_i;
        crc8fr_pkg::CFG_CODE_END:    code_end_q    <= cfg_data_i;
        crc8fr_pkg::CFG_CODE_REBOOT: code_reboot_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Frame state
  // --------------------------------------------------------------------------
  crc8fr_pkg::phase_e phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  seen_q, seen_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  first_q, first_d;
  logic [31:0] shift_q, shift_d;
  logic [15:0] temp_q, temp_d;
  logic [15:0] hum_q, hum_d;
  logic        rdy_flag_q, rdy_flag_d;

  // Output register
  logic        out_valid_q;
  logic        kind_q;
  logic [7:0]  data_q, off_q;
  logic [1:0]  cls_q, st_q;
  logic [2:0]  cmd_q;
  logic [15:0] otemp_q, ohum_q;
  logic        ovalid_flag_q;

  // Result of the byte being transferred
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_data, res_off;
  logic [1:0]  res_cls, res_st;
  logic [2:0]  res_cmd;

  logic        in_fire;
  logic [7:0]  crc_seed, crc_next;
  logic [7:0]  seen_inc;

  // The output register is the only buffer: take a byte when it is free
  // or is being drained this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Hunt phase seeds the CRC afresh with the preamble byte.
  assign crc_seed = (phase_q == crc8fr_pkg::PH_HUNT) ? crc8fr_pkg::CRC_INIT : crc_q;
  assign crc_next = crc8fr_pkg::crc8_step(crc_seed, rx_byte_i);
  assign seen_inc = seen_q + 8'd1;

  always_comb begin
    phase_d    = phase_q;
    type_d     = type_q;
    len_d      = len_q;
    seen_d     = seen_q;
    crc_d      = crc_q;
    first_d    = first_q;
    shift_d    = shift_q;
    temp_d     = temp_q;
    hum_d      = hum_q;
    rdy_flag_d = rdy_flag_q;

    res_valid = 1'b0;
    res_kind  = crc8fr_pkg::KIND_PAYLOAD;
    res_data  = 8'd0;
    res_off   = 8'd0;
    res_cls   = crc8fr_pkg::CLS_SENSOR;
    res_st    = crc8fr_pkg::ST_OK;
    res_cmd   = crc8fr_pkg::CMD_NONE;

    if (in_fire) begin
      unique case (phase_q)
        crc8fr_pkg::PH_HUNT: begin
          // junk before the preamble is dropped silently
          if (rx_byte_i == preamble_q) begin
            crc_d   = crc_next;
            phase_d = crc8fr_pkg::PH_TYPE;
          end
        end
        crc8fr_pkg::PH_TYPE: begin
          type_d  = rx_byte_i;
          crc_d   = crc_next;
          phase_d = crc8fr_pkg::PH_LEN;
        end
        crc8fr_pkg::PH_LEN: begin
          len_d   = rx_byte_i;
          crc_d   = crc_next;
          seen_d  = 8'd0;
          first_d = 8'd0;
          shift_d = 32'd0;
          // zero length goes straight to the CRC byte
          phase_d = (rx_byte_i == 8'd0) ? crc8fr_pkg::PH_CRC : crc8fr_pkg::PH_PAY;
        end
        crc8fr_pkg::PH_PAY: begin
          crc_d   = crc_next;
          if (seen_q == 8'd0) begin
            first_d = rx_byte_i;
          end
          shift_d = {shift_q[23:0], rx_byte_i};
          seen_d  = seen_inc;
          if (seen_inc == len_q) begin
            phase_d = crc8fr_pkg::PH_CRC;
          end
          res_valid = 1'b1;
          res_data  = rx_byte_i;
          res_off   = seen_q;
        end
        crc8fr_pkg::PH_CRC: begin
          phase_d   = crc8fr_pkg::PH_HUNT;
          crc_d     = crc8fr_pkg::CRC_INIT;
          res_valid = 1'b1;
          res_kind  = crc8fr_pkg::KIND_FRAME;
          // first match in register order wins
          if (type_q == type_sensor_q) begin
            res_cls = crc8fr_pkg::CLS_SENSOR;
          end else if (type_q == type_ack_q) begin
            res_cls = crc8fr_pkg::CLS_ACK;
          end else if (type_q == type_cmd_q) begin
            res_cls = crc8fr_pkg::CLS_COMMAND;
          end else begin
            res_cls = crc8fr_pkg::CLS_UNKNOWN;
          end

          if (rx_byte_i != crc_q) begin
            res_st = crc8fr_pkg::ST_CRC_ERR;
          end else if (res_cls == crc8fr_pkg::CLS_SENSOR) begin
            // under hold the frame is reported ok and changes nothing
            if (!sensor_hold_i) begin
              if (len_q == crc8fr_pkg::SENSOR_PAY_LEN) begin
                temp_d     = shift_q[31:16];
                hum_d      = shift_q[15:0];
                rdy_flag_d = 1'b1;
              end else begin
                res_st = crc8fr_pkg::ST_BAD_LEN;
              end
            end
          end else if (res_cls == crc8fr_pkg::CLS_ACK ||
                       res_cls == crc8fr_pkg::CLS_COMMAND) begin
            if (len_q == 8'd0) begin
              res_st = crc8fr_pkg::ST_TOO_SHORT;
            end else if (res_cls == crc8fr_pkg::CLS_COMMAND) begin
              if (first_q == code_init_q) begin
                res_cmd = crc8fr_pkg::CMD_INIT;
              end else if (first_q == code_data_q) begin
                res_cmd = crc8fr_pkg::CMD_DATA;
              end else if (first_q == code_end_q) begin
                res_cmd = crc8fr_pkg::CMD_END;
              end else if (first_q == code_reboot_q) begin
                res_cmd = crc8fr_pkg::CMD_REBOOT;
              end else begin
                res_cmd = crc8fr_pkg::CMD_UNKNOWN;
              end
            end
          end
        end
        default: begin
          phase_d = crc8fr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= crc8fr_pkg::PH_HUNT;
      type_q     <= 8'd0;
      len_q      <= 8'd0;
      seen_q     <= 8'd0;
      crc_q      <= crc8fr_pkg::CRC_INIT;
      first_q    <= 8'd0;
      shift_q    <= 32'd0;
      temp_q     <= 16'd0;
      hum_q      <= 16'd0;
      rdy_flag_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      type_q     <= type_d;
      len_q      <= len_d;
      seen_q     <= seen_d;
      crc_q      <= crc_d;
      first_q    <= first_d;
      shift_q    <= shift_d;
      temp_q     <= temp_d;
      hum_q      <= hum_d;
      rdy_flag_q <= rdy_flag_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: control reset, payload loaded on a new result
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      kind_q        <= res_kind;
      data_q        <= res_data;
      off_q         <= res_off;
      cls_q         <= res_cls;
      st_q          <= res_st;
      cmd_q         <= res_cmd;
      otemp_q       <= temp_d;   // readings after this byte's update
      ohum_q        <= hum_d;
      ovalid_flag_q <= rdy_flag_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = kind_q;
  assign data_byte_o     = data_q;
  assign byte_offset_o   = off_q;
  assign frame_class_o   = cls_q;
  assign frame_status_o  = st_q;
  assign command_class_o = cmd_q;
  assign temperature_o   = $signed(otemp_q);
  assign humidity_o      = $signed(ohum_q);
  assign reading_valid_o = ovalid_flag_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pay_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == crc8fr_pkg::PH_PAY |=>
      out_valid_o && result_kind_o == crc8fr_pkg::KIND_PAYLOAD)
    else $error("payload byte transfer gave no payload result");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == crc8fr_pkg::PH_CRC |=>
      out_valid_o && result_kind_o == crc8fr_pkg::KIND_FRAME &&
      phase_q == crc8fr_pkg::PH_HUNT && crc_q == crc8fr_pkg::CRC_INIT)
    else $error("CRC byte did not end the frame");

  a_pay_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == crc8fr_pkg::PH_PAY |-> seen_q < len_q)
    else $error("payload count ran past frame length");

  a_flag_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy_flag_q |=> rdy_flag_q)
    else $error("reading valid flag dropped");

endmodule

[bench/crc8_framed_packet_receiver_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_framed_packet_receiver_core_tb
// Self-checking bench for the framed CRC-8 receiver. A directed table runs
// first, then phases of random frames, each under a new register setting.
// Every output transfer is checked, field by field, against an in-bench
// model of the deframer.
// ----------------------------------------------------------------------------
module crc8_framed_packet_receiver_core_tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 4;   // settle time after the last pending result
  localparam int unsigned PHASE_BYTES  = 16;  // minimum frame bytes per random phase
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned LONG_STALL   = 300; // receiver hold-off, in cycles
  localparam int unsigned IDX_W        = crc8fr_pkg::CfgIdxW;

  // One output transfer as the model sees it
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [7:0]  off;
    logic [1:0]  cls;
    logic [1:0]  st;
    logic [2:0]  cmd;
    logic [15:0] temp;
    logic [15:0] hum;
    logic        rv;
  } rx_result_t;

  // Directed table: how each row's byte is formed
  typedef enum {B_RAW, B_SOF, B_MID, B_CRC_OK, B_CRC_BAD} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [7:0] val;
    logic       hold;
    bit         typed;   // frame-end fields typed in below
    logic [1:0] cls;
    logic [1:0] st;
    logic [2:0] cmd;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic                   in_valid      = 1'b0;
  logic [7:0]             rx_byte       = 8'h00;
  logic                   sensor_hold   = 1'b0;
  logic                   out_ready     = 1'b0;
  logic                   cfg_we        = 1'b0;
  logic [IDX_W-1:0]       cfg_idx       = '0;
  logic [7:0]             cfg_data      = 8'h00;

  logic                   in_ready_o;
  logic                   out_valid_o;
  logic                   result_kind_o;
  logic [7:0]             data_byte_o;
  logic [7:0]             byte_offset_o;
  logic [1:0]             frame_class_o;
  logic [1:0]             frame_status_o;
  logic [2:0]             command_class_o;
  logic signed [15:0]     temperature_o;
  logic signed [15:0]     humidity_o;
  logic                   reading_valid_o;

  crc8_framed_packet_receiver_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte),
    .sensor_hold_i   (sensor_hold),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .result_kind_o   (result_kind_o),
    .data_byte_o     (data_byte_o),
    .byte_offset_o   (byte_offset_o),
    .frame_class_o   (frame_class_o),
    .frame_status_o  (frame_status_o),
    .command_class_o (command_class_o),
    .temperature_o   (temperature_o),
    .humidity_o      (humidity_o),
    .reading_valid_o (reading_valid_o),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Deframer model: register shadow plus frame state
  // --------------------------------------------------------------------------
  logic [7:0]  cfg_shadow [0:7] = '{8'hAA, 8'd1, 8'd2, 8'd3, 8'd1, 8'd2, 8'd3, 8'd4};
  crc8fr_pkg::phase_e m_phase = crc8fr_pkg::PH_HUNT;
  logic [7:0]  m_type  = '0;
  logic [7:0]  m_len   = '0;
  logic [7:0]  m_seen  = '0;
  logic [7:0]  m_crc   = crc8fr_pkg::CRC_INIT;
  logic [7:0]  m_first = '0;
  logic [31:0] m_shift = '0;
  logic [15:0] m_temp  = '0;
  logic [15:0] m_hum   = '0;
  logic        m_valid = 1'b0;

  rx_result_t  pending_results [$];
  int unsigned errors = 0;

  // CRC-8 poly 0x07, fed one bit at a time, MSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? crc8fr_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // Steps the model by one accepted byte; returns 1 when a result is due
  function automatic bit predict_byte(input logic [7:0] b, input logic h,
                                      output rx_result_t r);
    bit         emit;
    logic [1:0] cls;
    logic [1:0] st;
    logic [2:0] cmd;
    emit = 1'b0;
    r    = '0;
    case (m_phase)
      crc8fr_pkg::PH_HUNT: begin
        // junk is dropped until the preamble shows up
        if (b == cfg_shadow[crc8fr_pkg::CFG_PREAMBLE]) begin
          m_crc   = crc8_next(crc8fr_pkg::CRC_INIT, b);
          m_phase = crc8fr_pkg::PH_TYPE;
        end
      end
      crc8fr_pkg::PH_TYPE: begin
        m_type  = b;
        m_crc   = crc8_next(m_crc, b);
        m_phase = crc8fr_pkg::PH_LEN;
      end
      crc8fr_pkg::PH_LEN: begin
        m_len   = b;
        m_crc   = crc8_next(m_crc, b);
        m_seen  = '0;
        m_first = '0;
        m_shift = '0;
        m_phase = (b == 8'd0) ? crc8fr_pkg::PH_CRC : crc8fr_pkg::PH_PAY;
      end
      crc8fr_pkg::PH_PAY: begin
        r.kind = crc8fr_pkg::KIND_PAYLOAD;
        r.data = b;
        r.off  = m_seen;
        r.cls  = crc8fr_pkg::CLS_SENSOR;
        r.st   = crc8fr_pkg::ST_OK;
        r.cmd  = crc8fr_pkg::CMD_NONE;
        m_crc  = crc8_next(m_crc, b);
        if (m_seen == 8'd0) m_first = b;
        m_shift = {m_shift[23:0], b};
        m_seen  = m_seen + 8'd1;
        if (m_seen == m_len) m_phase = crc8fr_pkg::PH_CRC;
        emit = 1'b1;
      end
      default: begin
        // CRC byte closes the frame; first matching type register wins
        if (m_type == cfg_shadow[crc8fr_pkg::CFG_TYPE_SENSOR]) begin
          cls = crc8fr_pkg::CLS_SENSOR;
        end else if (m_type == cfg_shadow[crc8fr_pkg::CFG_TYPE_ACK]) begin
          cls = crc8fr_pkg::CLS_ACK;
        end else if (m_type == cfg_shadow[crc8fr_pkg::CFG_TYPE_CMD]) begin
          cls = crc8fr_pkg::CLS_COMMAND;
        end else begin
          cls = crc8fr_pkg::CLS_UNKNOWN;
        end
        st  = crc8fr_pkg::ST_OK;
        cmd = crc8fr_pkg::CMD_NONE;
        if (b != m_crc) begin
          st = crc8fr_pkg::ST_CRC_ERR;
        end else if (cls == crc8fr_pkg::CLS_SENSOR) begin
          if (!h) begin
            if (m_len == crc8fr_pkg::SENSOR_PAY_LEN) begin
              m_temp  = m_shift[31:16];
              m_hum   = m_shift[15:0];
              m_valid = 1'b1;
            end else begin
              st = crc8fr_pkg::ST_BAD_LEN;
            end
          end
        end else if (cls == crc8fr_pkg::CLS_ACK || cls == crc8fr_pkg::CLS_COMMAND) begin
          if (m_len == 8'd0) begin
            st = crc8fr_pkg::ST_TOO_SHORT;
          end else if (cls == crc8fr_pkg::CLS_COMMAND) begin
            if (m_first == cfg_shadow[crc8fr_pkg::CFG_CODE_INIT]) begin
              cmd = crc8fr_pkg::CMD_INIT;
            end else if (m_first == cfg_shadow[crc8fr_pkg::CFG_CODE_DATA]) begin
              cmd = crc8fr_pkg::CMD_DATA;
            end else if (m_first == cfg_shadow[crc8fr_pkg::CFG_CODE_END]) begin
              cmd = crc8fr_pkg::CMD_END;
            end else if (m_first == cfg_shadow[crc8fr_pkg::CFG_CODE_REBOOT]) begin
              cmd = crc8fr_pkg::CMD_REBOOT;
            end else begin
              cmd = crc8fr_pkg::CMD_UNKNOWN;
            end
          end
        end
        m_crc   = crc8fr_pkg::CRC_INIT;
        m_phase = crc8fr_pkg::PH_HUNT;
        r.kind  = crc8fr_pkg::KIND_FRAME;
        r.cls   = cls;
        r.st    = st;
        r.cmd   = cmd;
        emit    = 1'b1;
      end
    endcase
    r.temp = m_temp;
    r.hum  = m_hum;
    r.rv   = m_valid;
    return emit;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  bit in_burst = 1'b0;

  // Offers one byte after a random gap and waits for its transfer. Rows with
  // typed fields take those in place of the model's frame-end fields.
  task automatic push_byte(input logic [7:0] b, input logic h,
                           input bit typed = 1'b0,
                           input logic [1:0] t_cls = crc8fr_pkg::CLS_SENSOR,
                           input logic [1:0] t_st = crc8fr_pkg::ST_OK,
                           input logic [2:0] t_cmd = crc8fr_pkg::CMD_NONE);
    int         gap;
    rx_result_t exp;
    bit         due;
    if ($urandom_range(0, 63) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    sensor_hold <= h;
    do @(posedge clk_i); while (!in_ready_o);
    due = predict_byte(b, h, exp);
    if (typed) begin
      exp.kind = crc8fr_pkg::KIND_FRAME;
      exp.data = '0;
      exp.off  = '0;
      exp.cls  = t_cls;
      exp.st   = t_st;
      exp.cmd  = t_cmd;
    end
    if (due || typed) pending_results.push_back(exp);
  endtask

  // Stops offering, waits out every pending result plus the pipeline
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Writes all eight registers; the setting depends on the phase number
  task automatic program_cfg(input int unsigned ph);
    logic [7:0] vals [0:7];
    logic [7:0] tv;
    logic [7:0] cv;
    tv = 8'($urandom);
    cv = 8'($urandom);
    for (int i = 0; i < 8; i++) begin
      case (ph % 5)
        0: vals[i] = 8'($urandom);
        1: vals[i] = 8'h00;                        // all registers at minimum
        2: vals[i] = 8'hFF;                        // all registers at maximum
        3: vals[i] = (i == 0) ? 8'($urandom) : ((i < 4) ? tv : cv); // equal codes
        default: vals[i] = (i == 0) ? 8'hAA : ((i < 4) ? 8'(i) : 8'(i - 3));
      endcase
    end
    for (int i = 0; i < 8; i++) begin
      @(negedge clk_i);
      cfg_we        <= 1'b1;
      cfg_idx       <= IDX_W'(i);
      cfg_data      <= vals[i];
      cfg_shadow[i]  = vals[i];  // input side is quiet, so no byte sees a stale value
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // One random frame under the current registers, optionally cut short.
  // Returns the number of frame bytes offered.
  task automatic send_frame(input bit force_long, input bit truncate,
                            output int unsigned sent);
    logic [7:0] pkt [$];
    logic [7:0] ty;
    logic [7:0] len;
    logic [7:0] crc;
    int         sel;
    sel = $urandom_range(0, 3);
    case (sel)
      0:       ty = cfg_shadow[crc8fr_pkg::CFG_TYPE_SENSOR];
      1:       ty = cfg_shadow[crc8fr_pkg::CFG_TYPE_ACK];
      2:       ty = cfg_shadow[crc8fr_pkg::CFG_TYPE_CMD];
      default: ty = 8'($urandom);
    endcase
    if (force_long)                                 len = 8'd255;
    else if ($urandom_range(0, 39) == 0)            len = 8'($urandom_range(128, 255));
    else if (sel == 0 && $urandom_range(0, 3) != 0) len = crc8fr_pkg::SENSOR_PAY_LEN;
    else                                            len = 8'($urandom_range(0, 8));
    pkt.push_back(cfg_shadow[crc8fr_pkg::CFG_PREAMBLE]);
    pkt.push_back(ty);
    pkt.push_back(len);
    for (int i = 0; i < len; i++) pkt.push_back(8'($urandom));
    // command frames mostly carry one of the known codes
    if (sel == 2 && len != 0 && $urandom_range(0, 3) != 0)
      pkt[3] = cfg_shadow[crc8fr_pkg::CFG_CODE_INIT + $urandom_range(0, 3)];
    crc = crc8fr_pkg::CRC_INIT;
    foreach (pkt[i]) crc = crc8_next(crc, pkt[i]);
    if ($urandom_range(0, 6) == 0) crc ^= 8'($urandom_range(1, 255));
    pkt.push_back(crc);
    if (truncate) repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
    // some line noise ahead of the frame
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'($urandom));
    foreach (pkt[i]) push_byte(pkt[i], ($urandom_range(0, 3) == 0));
    sent = pkt.size();
  endtask

  // --------------------------------------------------------------------------
  // Output side: random ready, one long hold-off, field checks
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      errors++;
    end
  endtask

  initial begin : result_sink
    int          gap;
    bit          burst;
    int unsigned n_xfer;
    rx_result_t  exp;
    burst  = 1'b0;
    n_xfer = 0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 63) == 0) burst = ~burst;
      gap = burst ? 0 : $urandom_range(0, 17);
      // once, hold off long enough for the output register to fill and
      // the input side to stall while the sender keeps offering
      if (n_xfer == 60) gap = LONG_STALL;
      @(negedge clk_i);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      n_xfer++;
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing pending, expected none, actual kind %0d",
                 $time, result_kind_o);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        check_field("result_kind",   32'(exp.kind), 32'(result_kind_o));
        check_field("data_byte",     32'(exp.data), 32'(data_byte_o));
        check_field("byte_offset",   32'(exp.off),  32'(byte_offset_o));
        check_field("frame_class",   32'(exp.cls),  32'(frame_class_o));
        check_field("frame_status",  32'(exp.st),   32'(frame_status_o));
        check_field("command_class", 32'(exp.cmd),  32'(command_class_o));
        check_field("temperature",   32'(exp.temp), 32'($unsigned(temperature_o)));
        check_field("humidity",      32'(exp.hum),  32'($unsigned(humidity_o)));
        check_field("reading_valid", 32'(exp.rv),   32'(reading_valid_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed table, then random phases
  // --------------------------------------------------------------------------
  stim_row_t dir_rows [$];

  task automatic add_row(input row_kind_e k, input logic [7:0] v, input logic h = 1'b0,
                         input bit typed = 1'b0,
                         input logic [1:0] cls = crc8fr_pkg::CLS_SENSOR,
                         input logic [1:0] st = crc8fr_pkg::ST_OK,
                         input logic [2:0] cmd = crc8fr_pkg::CMD_NONE);
    stim_row_t row;
    row = '{k, v, h, typed, cls, st, cmd};
    dir_rows.push_back(row);
  endtask

  initial begin : stimulus
    logic [7:0]  dir_crc;
    logic [7:0]  b;
    int unsigned phase_bytes;
    int unsigned sent;
    dir_crc = crc8fr_pkg::CRC_INIT;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Defaults after reset: preamble AA, sensor 1, ack 2, command 3.
    // Junk while hunting gives nothing.
    add_row(B_RAW, 8'h00);
    // Sensor frame with extreme readings: temperature 0x8000, humidity 0x7FFF
    add_row(B_SOF, 8'hAA);
    add_row(B_MID, 8'h01);
    add_row(B_MID, 8'h04);
    add_row(B_MID, 8'h80);
    add_row(B_MID, 8'h00);
    add_row(B_MID, 8'h7F);
    add_row(B_MID, 8'hFF);
    add_row(B_CRC_OK, 8'h00, 1'b0, 1'b1, crc8fr_pkg::CLS_SENSOR, crc8fr_pkg::ST_OK,
            crc8fr_pkg::CMD_NONE);
    // Command frame of zero length: CRC right after the length byte
    add_row(B_SOF, 8'hAA);
    add_row(B_MID, 8'h03);
    add_row(B_MID, 8'h00);
    add_row(B_CRC_OK, 8'h00, 1'b0, 1'b1, crc8fr_pkg::CLS_COMMAND, crc8fr_pkg::ST_TOO_SHORT,
            crc8fr_pkg::CMD_NONE);
    // Unknown type, bad CRC: class still reported
    add_row(B_SOF, 8'hAA);
    add_row(B_MID, 8'hFE);
    add_row(B_MID, 8'h00);
    add_row(B_CRC_BAD, 8'h00, 1'b0, 1'b1, crc8fr_pkg::CLS_UNKNOWN, crc8fr_pkg::ST_CRC_ERR,
            crc8fr_pkg::CMD_NONE);
    // Sensor frame of wrong length, no hold
    add_row(B_SOF, 8'hAA);
    add_row(B_MID, 8'h01);
    add_row(B_MID, 8'h01);
    add_row(B_MID, 8'h55);
    add_row(B_CRC_OK, 8'h00, 1'b0, 1'b1, crc8fr_pkg::CLS_SENSOR, crc8fr_pkg::ST_BAD_LEN,
            crc8fr_pkg::CMD_NONE);
    // Sensor frame under hold: length not checked, nothing stored
    add_row(B_SOF, 8'hAA);
    add_row(B_MID, 8'h01);
    add_row(B_MID, 8'h00);
    add_row(B_CRC_OK, 8'h00, 1'b1, 1'b1, crc8fr_pkg::CLS_SENSOR, crc8fr_pkg::ST_OK,
            crc8fr_pkg::CMD_NONE);

    foreach (dir_rows[i]) begin
      b = dir_rows[i].val;
      case (dir_rows[i].kind)
        B_SOF:     dir_crc = crc8_next(crc8fr_pkg::CRC_INIT, b);
        B_MID:     dir_crc = crc8_next(dir_crc, b);
        B_CRC_OK:  b = dir_crc;
        B_CRC_BAD: b = dir_crc ^ 8'h5A;
        default:   ;
      endcase
      push_byte(b, dir_rows[i].hold, dir_rows[i].typed,
                dir_rows[i].cls, dir_rows[i].st, dir_rows[i].cmd);
    end

    // Random phases; a phase may end mid-frame, so some register writes
    // land while a frame is half read.
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      program_cfg(ph);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        // one maximum-length frame, unless cut short, reaches payload offset 254
        send_frame((ph == 2 && phase_bytes == 0), ($urandom_range(0, 9) == 0), sent);
        phase_bytes += sent;
      end
      if ($urandom_range(0, 1) != 0) send_frame(1'b0, 1'b1, sent);
    end

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
